// ===== src/svpwm_pkg.sv =====
// Shared types, constants and lookup functions for the SVPWM sector and compare pipeline.
package svpwm_pkg;

  // Phase reference width, Q1.(SAMPLE_WIDTH-1)
  localparam int SAMPLE_WIDTH = 16;
  localparam int PERIOD_W     = 16;
  localparam int SEC_W        = 3;
  localparam int VEC_W        = 3;
  localparam int CMP_W        = 16;

  // Twice a phase difference, clamped non-negative
  localparam int DUTY_W = SAMPLE_WIDTH + 1;
  // Sum of both active duties
  localparam int SUM_W  = SAMPLE_WIDTH + 2;
  // Divider partial remainder, below twice the divisor
  localparam int REM_W  = SAMPLE_WIDTH + 3;
  // Compare numerators in half-duty units, at most two full duties
  localparam int HALF_W = SAMPLE_WIDTH + 2;

  // Ratio quotient: one spare bit below the 2^-30 grid, dropped at the end
  localparam int Q_W                 = 32;
  localparam int DIV_STEPS_PER_STAGE = 4;
  localparam int DIV_STAGES          = Q_W / DIV_STEPS_PER_STAGE;
  localparam int RATIO_FRAC          = 30;

  // One full duty: 3 * 2^(SAMPLE_WIDTH-1)
  localparam logic [DUTY_W-1:0] FULL_DUTY = DUTY_W'(3) << (SAMPLE_WIDTH - 1);

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(14399);

  // Compare scaling: (half * period + full) / (3 * 2^SAMPLE_WIDTH)
  localparam int PROD_W      = HALF_W + PERIOD_W;
  localparam int NUM_W       = PROD_W - SAMPLE_WIDTH;
  // floor(n / 3) = (n * ceil(2^20 / 3)) >> 20, exact for n below 2^19
  localparam int RECIP_W     = 19;
  localparam int RECIP_SHIFT = 20;
  localparam logic [RECIP_W-1:0] RECIP_THIRD = RECIP_W'(349526);
  localparam int MQ_W        = NUM_W + RECIP_W;
  localparam int CMP_RAW_W   = MQ_W - RECIP_SHIFT;

  // Sector numbers
  localparam logic [SEC_W-1:0] SECTOR_1 = SEC_W'(1);
  localparam logic [SEC_W-1:0] SECTOR_2 = SEC_W'(2);
  localparam logic [SEC_W-1:0] SECTOR_3 = SEC_W'(3);
  localparam logic [SEC_W-1:0] SECTOR_4 = SEC_W'(4);
  localparam logic [SEC_W-1:0] SECTOR_5 = SEC_W'(5);
  localparam logic [SEC_W-1:0] SECTOR_6 = SEC_W'(6);

  // Switching vectors, bits A B C
  localparam logic [VEC_W-1:0] VEC_001 = 3'b001;
  localparam logic [VEC_W-1:0] VEC_010 = 3'b010;
  localparam logic [VEC_W-1:0] VEC_011 = 3'b011;
  localparam logic [VEC_W-1:0] VEC_100 = 3'b100;
  localparam logic [VEC_W-1:0] VEC_101 = 3'b101;
  localparam logic [VEC_W-1:0] VEC_110 = 3'b110;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  typedef struct packed {
    sample_t phase_a;
    sample_t phase_b;
    sample_t phase_c;
  } svpwm_in_t;

  typedef struct packed {
    logic [SEC_W-1:0] sector;
    logic [VEC_W-1:0] first_vector;
    logic [VEC_W-1:0] second_vector;
    logic [CMP_W-1:0] compare_zero;
    logic [CMP_W-1:0] compare_first;
    logic [CMP_W-1:0] compare_second;
    logic [CMP_W-1:0] compare_last;
    logic             overmodulation;
  } svpwm_out_t;

  typedef struct packed {
    logic [SEC_W-1:0]  sector;
    logic [DUTY_W-1:0] t1;
    logic [DUTY_W-1:0] t2;
    logic [SUM_W-1:0]  sum;
    logic              neg;
    logic              clip;
  } svpwm_duty_t;

  typedef struct packed {
    svpwm_duty_t    duty;
    logic [Q_W-1:0] quot;
  } svpwm_ratio_t;

  // Sign pattern {c>a, a>b, b>c} to sector
  function automatic logic [SEC_W-1:0] sector_of_code(input logic [2:0] code);
    logic [SEC_W-1:0] sec;
    case (code)
      3'd1:    sec = SECTOR_2;
      3'd2:    sec = SECTOR_6;
      3'd4:    sec = SECTOR_4;
      3'd5:    sec = SECTOR_3;
      3'd6:    sec = SECTOR_5;
      default: sec = SECTOR_1;
    endcase
    return sec;
  endfunction

  function automatic logic [VEC_W-1:0] first_vec(input logic [SEC_W-1:0] sec);
    logic [VEC_W-1:0] v;
    case (sec)
      SECTOR_2, SECTOR_3: v = VEC_010;
      SECTOR_4, SECTOR_5: v = VEC_001;
      default:            v = VEC_100;
    endcase
    return v;
  endfunction

  function automatic logic [VEC_W-1:0] second_vec(input logic [SEC_W-1:0] sec);
    logic [VEC_W-1:0] v;
    case (sec)
      SECTOR_3, SECTOR_4: v = VEC_011;
      SECTOR_5, SECTOR_6: v = VEC_101;
      default:            v = VEC_110;
    endcase
    return v;
  endfunction

endpackage

// ===== src/svpwm_sector.sv =====
// Sector detection and clamped active-duty pipeline (two stages).
module svpwm_sector (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  svpwm_pkg::svpwm_in_t   in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output svpwm_pkg::svpwm_duty_t out_data
);

  localparam int SW = svpwm_pkg::SAMPLE_WIDTH;

  logic                          v0;
  logic                          v1;
  logic                          en0;
  logic                          en1;
  svpwm_pkg::sample_t            a0;
  svpwm_pkg::sample_t            b0;
  svpwm_pkg::sample_t            c0;
  logic [svpwm_pkg::SEC_W-1:0]   sec0;
  logic [svpwm_pkg::SEC_W-1:0]   sec_next;
  svpwm_pkg::svpwm_duty_t        duty1;
  svpwm_pkg::svpwm_duty_t        duty_next;

  assign en1      = !v1 || out_ready;
  assign en0      = !v0 || en1;
  assign in_ready = en0;

  always_comb begin
    logic [2:0] code;
    code[0]  = $signed(in_data.phase_b) > $signed(in_data.phase_c);
    code[1]  = $signed(in_data.phase_a) > $signed(in_data.phase_b);
    code[2]  = $signed(in_data.phase_c) > $signed(in_data.phase_a);
    sec_next = svpwm_pkg::sector_of_code(code);
  end

  always_comb begin
    svpwm_pkg::sample_t p1;
    svpwm_pkg::sample_t m1;
    svpwm_pkg::sample_t p2;
    svpwm_pkg::sample_t m2;
    logic signed [SW:0] d1;
    logic signed [SW:0] d2;
    case (sec0)
      svpwm_pkg::SECTOR_1: begin p1 = a0; m1 = b0; p2 = b0; m2 = c0; end
      svpwm_pkg::SECTOR_2: begin p1 = b0; m1 = a0; p2 = a0; m2 = c0; end
      svpwm_pkg::SECTOR_3: begin p1 = b0; m1 = c0; p2 = c0; m2 = a0; end
      svpwm_pkg::SECTOR_4: begin p1 = c0; m1 = b0; p2 = b0; m2 = a0; end
      svpwm_pkg::SECTOR_5: begin p1 = c0; m1 = a0; p2 = a0; m2 = b0; end
      default:             begin p1 = a0; m1 = c0; p2 = c0; m2 = b0; end
    endcase
    d1 = {p1[SW-1], p1} - {m1[SW-1], m1};
    d2 = {p2[SW-1], p2} - {m2[SW-1], m2};
    duty_next.sector = sec0;
    // Drop negative duties to zero and flag them
    duty_next.neg    = d1[SW] || d2[SW];
    duty_next.t1     = d1[SW] ? '0 : {d1[SW-1:0], 1'b0};
    duty_next.t2     = d2[SW] ? '0 : {d2[SW-1:0], 1'b0};
    duty_next.sum    = svpwm_pkg::SUM_W'(duty_next.t1) + svpwm_pkg::SUM_W'(duty_next.t2);
    duty_next.clip   = duty_next.sum > svpwm_pkg::SUM_W'(svpwm_pkg::FULL_DUTY);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      if (en0) v0 <= in_valid;
      if (en1) v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      a0   <= in_data.phase_a;
      b0   <= in_data.phase_b;
      c0   <= in_data.phase_c;
      sec0 <= sec_next;
    end
    if (en1) duty1 <= duty_next;
  end

  assign out_valid = v1;
  assign out_data  = duty1;

endmodule

// ===== src/svpwm_div.sv =====
// Pipelined restoring divider forming the first-duty share t1 / (t1 + t2).
module svpwm_div (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  svpwm_pkg::svpwm_duty_t  in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output svpwm_pkg::svpwm_ratio_t out_data
);

  localparam int NS   = svpwm_pkg::DIV_STAGES;
  localparam int RW   = svpwm_pkg::REM_W;
  localparam int QW   = svpwm_pkg::Q_W;
  localparam int LAST = NS - 1;

  logic [NS-1:0]          v;
  logic [NS-1:0]          vin;
  logic [NS-1:0]          en;
  svpwm_pkg::svpwm_duty_t duty_r   [NS];
  logic [RW-1:0]          rem_r    [NS];
  logic [QW-1:0]          quot_r   [NS];
  svpwm_pkg::svpwm_duty_t duty_in  [NS];
  logic [RW-1:0]          rem_in   [NS];
  logic [QW-1:0]          quot_in  [NS];
  logic [RW-1:0]          rem_next [NS];
  logic [QW-1:0]          quot_next[NS];

  // Stall chain: a stage loads when empty or when its successor loads
  always_comb begin
    en[LAST] = !v[LAST] || out_ready;
    for (int g = LAST - 1; g >= 0; g--) begin
      en[g] = !v[g] || en[g+1];
    end
  end

  always_comb begin
    logic take;
    vin[0]     = in_valid;
    duty_in[0] = in_data;
    rem_in[0]  = RW'(in_data.t1);
    quot_in[0] = '0;
    for (int g = 1; g < NS; g++) begin
      vin[g]     = v[g-1];
      duty_in[g] = duty_r[g-1];
      rem_in[g]  = rem_r[g-1];
      quot_in[g] = quot_r[g-1];
    end
    for (int g = 0; g < NS; g++) begin
      rem_next[g]  = rem_in[g];
      quot_next[g] = quot_in[g];
      for (int k = 0; k < svpwm_pkg::DIV_STEPS_PER_STAGE; k++) begin
        take = rem_next[g] >= RW'(duty_in[g].sum);
        if (take) rem_next[g] = rem_next[g] - RW'(duty_in[g].sum);
        quot_next[g] = {quot_next[g][QW-2:0], take};
        rem_next[g]  = rem_next[g] << 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int g = 0; g < NS; g++) begin
        if (en[g]) v[g] <= vin[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < NS; g++) begin
      if (en[g]) begin
        duty_r[g] <= duty_in[g];
        rem_r[g]  <= rem_next[g];
        quot_r[g] <= quot_next[g];
      end
    end
  end

  assign in_ready      = en[0];
  assign out_valid     = v[LAST];
  assign out_data.duty = duty_r[LAST];
  assign out_data.quot = quot_r[LAST];

endmodule

// ===== src/svpwm_scale.sv =====
// Duty rescaling on overmodulation and period scaling into compare values (five stages).
module svpwm_scale (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  svpwm_pkg::svpwm_ratio_t             in_data,
  input  logic [svpwm_pkg::PERIOD_W-1:0]      period,
  output logic                                out_valid,
  input  logic                                out_ready,
  output svpwm_pkg::svpwm_out_t               out_data
);

  localparam int SW  = svpwm_pkg::SAMPLE_WIDTH;
  localparam int DW  = svpwm_pkg::DUTY_W;
  localparam int HW  = svpwm_pkg::HALF_W;
  localparam int PW  = svpwm_pkg::PROD_W;
  localparam int MW  = svpwm_pkg::MQ_W;
  localparam int QW  = svpwm_pkg::Q_W;
  localparam int Q3W = QW + 1;
  localparam int WW  = Q3W + SW - 1;
  localparam int NS  = 5;

  logic [NS-1:0] v;
  logic [NS-1:0] en;

  logic [svpwm_pkg::SEC_W-1:0] sec_r [NS];
  logic                        ov_r  [NS];

  logic [DW-1:0]  s0_t1;
  logic [DW-1:0]  s0_t2;
  logic [DW-1:0]  t1_next;
  logic [DW-1:0]  t2_next;
  logic [HW-1:0]  s1_half [4];
  logic [HW-1:0]  half_next [4];
  logic [PW-1:0]  s2_prod [4];
  logic [MW-1:0]  s3_mq [4];
  logic [MW-1:0]  mq_next [4];
  logic [svpwm_pkg::CMP_W-1:0] s4_cmp [4];
  logic [svpwm_pkg::CMP_W-1:0] cmp_next [4];

  always_comb begin
    en[NS-1] = !v[NS-1] || out_ready;
    for (int g = NS - 2; g >= 0; g--) begin
      en[g] = !v[g] || en[g+1];
    end
  end

  // Rescale t1 onto the duty grid: (ratio * full) >> 30, ratio = quot >> 1
  always_comb begin
    logic [QW-2:0] ratio;
    logic [Q3W-1:0] ratio3;
    logic [WW-1:0]  wide;
    logic [DW-1:0]  t1_clip;
    ratio   = in_data.quot[QW-1:1];
    ratio3  = Q3W'(ratio) + Q3W'({ratio, 1'b0});
    wide    = {ratio3, {(SW - 1){1'b0}}};
    t1_clip = wide[svpwm_pkg::RATIO_FRAC +: DW];
    t1_next = in_data.duty.clip ? t1_clip : in_data.duty.t1;
    t2_next = in_data.duty.clip ? (svpwm_pkg::FULL_DUTY - t1_clip) : in_data.duty.t2;
  end

  // Cumulative half-duty numerators
  always_comb begin
    logic [DW-1:0] t0;
    t0 = svpwm_pkg::FULL_DUTY - s0_t1 - s0_t2;
    half_next[0] = HW'(t0);
    half_next[1] = half_next[0] + HW'(s0_t1);
    half_next[2] = half_next[1] + HW'({s0_t2, 1'b0});
    half_next[3] = half_next[2] + HW'(s0_t1);
  end

  // Round half up, divide by 2^SAMPLE_WIDTH by selection and by three by reciprocal
  always_comb begin
    logic [PW-1:0] num;
    for (int i = 0; i < 4; i++) begin
      num        = s2_prod[i] + PW'(svpwm_pkg::FULL_DUTY);
      mq_next[i] = MW'(num[SW +: svpwm_pkg::NUM_W]) * MW'(svpwm_pkg::RECIP_THIRD);
    end
  end

  always_comb begin
    logic [svpwm_pkg::CMP_RAW_W-1:0] raw;
    for (int i = 0; i < 4; i++) begin
      raw         = s3_mq[i][svpwm_pkg::RECIP_SHIFT +: svpwm_pkg::CMP_RAW_W];
      cmp_next[i] = (raw > svpwm_pkg::CMP_RAW_W'({svpwm_pkg::CMP_W{1'b1}})) ?
                    {svpwm_pkg::CMP_W{1'b1}} : raw[svpwm_pkg::CMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int g = 1; g < NS; g++) begin
        if (en[g]) v[g] <= v[g-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sec_r[0] <= in_data.duty.sector;
      ov_r[0]  <= in_data.duty.neg || in_data.duty.clip;
      s0_t1    <= t1_next;
      s0_t2    <= t2_next;
    end
    for (int g = 1; g < NS; g++) begin
      if (en[g]) begin
        sec_r[g] <= sec_r[g-1];
        ov_r[g]  <= ov_r[g-1];
      end
    end
    for (int i = 0; i < 4; i++) begin
      if (en[1]) s1_half[i] <= half_next[i];
      if (en[2]) s2_prod[i] <= PW'(s1_half[i]) * PW'(period);
      if (en[3]) s3_mq[i]   <= mq_next[i];
      if (en[4]) s4_cmp[i]  <= cmp_next[i];
    end
  end

  assign in_ready                = en[0];
  assign out_valid               = v[NS-1];
  assign out_data.sector         = sec_r[NS-1];
  assign out_data.first_vector   = svpwm_pkg::first_vec(sec_r[NS-1]);
  assign out_data.second_vector  = svpwm_pkg::second_vec(sec_r[NS-1]);
  assign out_data.compare_zero   = s4_cmp[0];
  assign out_data.compare_first  = s4_cmp[1];
  assign out_data.compare_second = s4_cmp[2];
  assign out_data.compare_last   = s4_cmp[3];
  assign out_data.overmodulation = ov_r[NS-1];

endmodule

// ===== src/svpwm_sector_duty_compare.sv =====
// Top level: space vector PWM sector, vector codes and compare values from three phase references.
// Pipeline: 15 register stages (2 sector, 8 divider, 5 scale), which a sample passes in order.
// Throughput: one sample per cycle unless result_ready stalls; a stage advances when empty or when its successor does.
// The divider retires four quotient bits per stage, which sets the eight middle stages.
// Reset (rst, synchronous, active high) empties the pipeline and loads period 14399.
module svpwm_sector_duty_compare (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             sample_valid,
  output logic                             sample_ready,
  input  svpwm_pkg::svpwm_in_t             sample,
  output logic                             result_valid,
  input  logic                             result_ready,
  output svpwm_pkg::svpwm_out_t            result,
  input  logic                             period_we,
  input  logic [svpwm_pkg::PERIOD_W-1:0]   period_wdata
);

  // Timer period register; to be written by the user only while the pipeline is empty, which the block does not enforce
  logic [svpwm_pkg::PERIOD_W-1:0] pwm_period;

  // Inter-segment transfers
  logic                    duty_valid;
  logic                    duty_ready;
  svpwm_pkg::svpwm_duty_t  duty;
  logic                    ratio_valid;
  logic                    ratio_ready;
  svpwm_pkg::svpwm_ratio_t ratio;

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_period <= svpwm_pkg::PERIOD_RESET;
    end else if (period_we) begin
      pwm_period <= period_wdata;
    end
  end

  // Sector from the signs of the phase differences, then the two clamped active duties
  svpwm_sector u_sector (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample_valid),
    .in_ready  (sample_ready),
    .in_data   (sample),
    .out_valid (duty_valid),
    .out_ready (duty_ready),
    .out_data  (duty)
  );

  // Share of the first duty in the active sum, needed when the pair overruns one period
  svpwm_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (duty_valid),
    .in_ready  (duty_ready),
    .in_data   (duty),
    .out_valid (ratio_valid),
    .out_ready (ratio_ready),
    .out_data  (ratio)
  );

  // Rescale on overmodulation, then scale by the period into the four compare points;
  // its last stage is the output register and holds a result until it is taken
  svpwm_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ratio_valid),
    .in_ready  (ratio_ready),
    .in_data   (ratio),
    .period    (pwm_period),
    .out_valid (result_valid),
    .out_ready (result_ready),
    .out_data  (result)
  );

  // An empty output stage must let the whole chain advance
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> sample_ready)
    else $error("sample_ready low with output stage empty");

  // Sector stays within one to six
  a_sector_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.sector >= svpwm_pkg::SECTOR_1 &&
                      result.sector <= svpwm_pkg::SECTOR_6))
    else $error("sector out of range");

  // Compare points are cumulative and so never decrease
  a_compare_order: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.compare_zero <= result.compare_first &&
                      result.compare_first <= result.compare_second &&
                      result.compare_second <= result.compare_last))
    else $error("compare values out of order");

  // Adjacent active vectors differ in exactly one phase
  a_vector_adjacent: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $onehot(result.first_vector ^ result.second_vector))
    else $error("active vectors not adjacent");

endmodule
